// File: hdl/url_path_decode_sanitize_top_assert.svh
// Assertion macros for the URL path decoder.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef URL_PATH_DECODE_SANITIZE_TOP_ASSERT_SVH
`define URL_PATH_DECODE_SANITIZE_TOP_ASSERT_SVH

// Plain property, checked at every edge outside reset.
`define UPDS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Trigger in this cycle, consequence in the next.
`define UPDS_ASSERT_NEXT(label, clk, rst_n, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/upds_pkg.sv
// Shared types, constants and character helpers for the URL path decoder.
// No dependencies.
package upds_pkg;

    localparam int MAX_URL_BYTES = 1024;
    localparam int EMIT_W        = $clog2(MAX_URL_BYTES + 1);
    localparam logic [EMIT_W-1:0] EMIT_MAX = EMIT_W'(MAX_URL_BYTES);

    localparam int CNT_W = 11;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // output queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int PUSH_MAX   = 3;
    localparam logic [FIFO_CNT_W-1:0] FIFO_ROOM_LIMIT = FIFO_CNT_W'(FIFO_DEPTH - PUSH_MAX);

    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_QMARK = 8'h3f;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_DOT   = 8'h2e;

    localparam logic [1:0] VERDICT_OK     = 2'd0;
    localparam logic [1:0] VERDICT_FORBID = 2'd1;
    localparam logic [1:0] VERDICT_TRAV   = 2'd2;
    localparam logic [1:0] VERDICT_OVFL   = 2'd3;

    localparam logic KIND_PATH    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef enum logic [2:0] {
        MODE_NORMAL,
        MODE_PCT0,
        MODE_PCT1,
        MODE_SLASH,
        MODE_DOT,
        MODE_MATCH,
        MODE_DONE
    } mode_t;

    typedef struct packed {
        mode_t             mode;
        logic [7:0]        la0;
        logic [1:0]        la_cnt;
        logic [CNT_W-1:0]  slash;
        logic [CNT_W-1:0]  dotdot;
        logic [EMIT_W-1:0] emitted;
        logic [1:0]        pend;
    } st_t;

    localparam st_t ST_RESET = '{
        mode:    MODE_NORMAL,
        la0:     8'h00,
        la_cnt:  2'd0,
        slash:   '0,
        dotdot:  '0,
        emitted: '0,
        pend:    VERDICT_OK
    };

    // working context while one byte is scanned
    typedef struct packed {
        st_t             st;
        logic [1:0]      n;
        logic [2:0][7:0] items;
    } ctx_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] path_byte;
        logic [1:0] verdict;
        logic       end_of_run;
    } out_item_t;

    typedef struct packed {
        logic [1:0]           cnt;
        out_item_t [2:0]      item;
    } push_t;

    function automatic logic is_forbidden(logic [7:0] v);
        return (v >= 8'h21 && v <= 8'h23) || v == 8'h26 || v == 8'h27 ||
               v == 8'h2a || v == 8'h3b || v == 8'h3c || v == 8'h3e ||
               v == 8'h3f || v == 8'h60 || v == 8'h7c;
    endfunction

    // {digit_ok, value}
    function automatic logic [4:0] hex_value(logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
        return r;
    endfunction

endpackage

// File: hdl/upds_step.sv
// Per-byte scanner: state registers plus the decode logic for one byte.
// Depends on upds_pkg and the assertion macro header.
`include "url_path_decode_sanitize_top_assert.svh"

module upds_step (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fire,
    input  logic [7:0]      url_byte,
    input  logic            last_byte,
    output upds_pkg::push_t push
);

    upds_pkg::st_t  st_reg;
    upds_pkg::st_t  st_next;
    upds_pkg::ctx_t ctx;
    upds_pkg::push_t push_c;

    function automatic upds_pkg::ctx_t f_finish(upds_pkg::ctx_t c, logic [1:0] v);
        upds_pkg::ctx_t r;
        r = c;
        if (r.st.pend == upds_pkg::VERDICT_OK) r.st.pend = v;
        r.st.mode = upds_pkg::MODE_DONE;
        return r;
    endfunction

    function automatic upds_pkg::ctx_t f_emit(upds_pkg::ctx_t c, logic [7:0] b);
        upds_pkg::ctx_t r;
        r = c;
        if (r.st.mode != upds_pkg::MODE_DONE) begin
            if (r.st.emitted >= upds_pkg::EMIT_MAX || r.n == 2'd3) begin
                r = f_finish(r, upds_pkg::VERDICT_OVFL);
            end else begin
                r.st.emitted = r.st.emitted + 1'b1;
                r.items[r.n] = b;
                r.n = r.n + 2'd1;
            end
        end
        return r;
    endfunction

    function automatic upds_pkg::ctx_t f_plain(upds_pkg::ctx_t c, logic [7:0] b, logic last);
        upds_pkg::ctx_t r;
        r = c;
        if (r.st.mode != upds_pkg::MODE_DONE) begin
            if (b == upds_pkg::CH_PCT) begin
                if (last) r = f_emit(r, b);
                else r.st.mode = upds_pkg::MODE_PCT0;
            end else if (b == upds_pkg::CH_QMARK) begin
                r = f_finish(r, upds_pkg::VERDICT_OK);
            end else if (b == upds_pkg::CH_SLASH) begin
                if (r.st.slash < upds_pkg::CNT_MAX) r.st.slash = r.st.slash + 1'b1;
                if (last) r = f_emit(r, upds_pkg::CH_SLASH);
                else r.st.mode = upds_pkg::MODE_SLASH;
            end else if (upds_pkg::is_forbidden(b)) begin
                r = f_finish(r, upds_pkg::VERDICT_FORBID);
            end else begin
                r = f_emit(r, b);
            end
        end
        return r;
    endfunction

    always_comb
    begin
        logic [4:0]                h1;
        logic [4:0]                h2;
        logic [7:0]                code;
        logic [7:0]                want;
        logic [upds_pkg::CNT_W-1:0] dd;

        ctx.st    = st_reg;
        ctx.n     = 2'd0;
        ctx.items = '0;
        h1   = upds_pkg::hex_value(st_reg.la0);
        h2   = upds_pkg::hex_value(url_byte);
        code = 8'h00;
        if (h1[4]) code = h2[4] ? {h1[3:0], h2[3:0]} : {4'h0, h1[3:0]};
        want = (st_reg.la_cnt >= 2'd2) ? upds_pkg::CH_SLASH : upds_pkg::CH_DOT;
        dd   = (st_reg.dotdot < upds_pkg::CNT_MAX) ? st_reg.dotdot + 1'b1 : st_reg.dotdot;

        case (st_reg.mode)
            upds_pkg::MODE_NORMAL:
            begin
                ctx = f_plain(ctx, url_byte, last_byte);
            end
            upds_pkg::MODE_PCT0:
            begin
                if (last_byte) begin
                    ctx.st.mode = upds_pkg::MODE_NORMAL;
                    ctx = f_emit(ctx, upds_pkg::CH_PCT);
                    ctx = f_plain(ctx, url_byte, 1'b1);
                end else begin
                    ctx.st.la0  = url_byte;
                    ctx.st.mode = upds_pkg::MODE_PCT1;
                end
            end
            upds_pkg::MODE_PCT1:
            begin
                ctx.st.mode = upds_pkg::MODE_NORMAL;
                if (upds_pkg::is_forbidden(code)) ctx = f_finish(ctx, upds_pkg::VERDICT_FORBID);
                else ctx = f_emit(ctx, code);
            end
            upds_pkg::MODE_SLASH:
            begin
                if (url_byte == upds_pkg::CH_SLASH) begin
                    if (last_byte) ctx = f_emit(ctx, upds_pkg::CH_SLASH);
                end else if (url_byte == upds_pkg::CH_DOT) begin
                    if (last_byte) begin
                        ctx.st.mode = upds_pkg::MODE_NORMAL;
                        ctx = f_emit(ctx, upds_pkg::CH_SLASH);
                        ctx = f_emit(ctx, upds_pkg::CH_DOT);
                    end else begin
                        ctx.st.mode = upds_pkg::MODE_DOT;
                    end
                end else begin
                    ctx.st.mode = upds_pkg::MODE_NORMAL;
                    ctx = f_emit(ctx, upds_pkg::CH_SLASH);
                    ctx = f_plain(ctx, url_byte, last_byte);
                end
            end
            upds_pkg::MODE_DOT:
            begin
                if (last_byte) begin
                    ctx.st.mode = upds_pkg::MODE_NORMAL;
                    ctx = f_emit(ctx, upds_pkg::CH_SLASH);
                    ctx = f_emit(ctx, upds_pkg::CH_DOT);
                    ctx = f_plain(ctx, url_byte, 1'b1);
                end else if (url_byte == upds_pkg::CH_DOT) begin
                    ctx.st.la_cnt = 2'd2;
                    ctx.st.dotdot = '0;
                    ctx.st.mode   = upds_pkg::MODE_MATCH;
                end else begin
                    ctx = f_finish(ctx, upds_pkg::VERDICT_OK);
                end
            end
            upds_pkg::MODE_MATCH:
            begin
                if (url_byte != want) begin
                    ctx = f_finish(ctx, upds_pkg::VERDICT_OK);
                end else if (st_reg.la_cnt >= 2'd2) begin
                    ctx.st.la_cnt = 2'd0;
                    ctx.st.dotdot = dd;
                    if (dd >= st_reg.slash) ctx = f_finish(ctx, upds_pkg::VERDICT_TRAV);
                end else begin
                    ctx.st.la_cnt = st_reg.la_cnt + 2'd1;
                end
            end
            default:
            begin
            end
        endcase

        for (int k = 0; k < 3; k++) begin
            push_c.item[k] = '{kind:       upds_pkg::KIND_PATH,
                               path_byte:  ctx.items[k],
                               verdict:    upds_pkg::VERDICT_OK,
                               end_of_run: 1'b0};
        end
        push_c.cnt = ctx.n;
        st_next    = ctx.st;

        if (last_byte) begin
            if (ctx.n == 2'd3) begin
                // no room for a fourth word: the verdict rides on the third
                push_c.item[2].verdict    = ctx.st.pend;
                push_c.item[2].end_of_run = 1'b1;
            end else begin
                push_c.item[ctx.n] = '{kind:       upds_pkg::KIND_VERDICT,
                                       path_byte:  8'h00,
                                       verdict:    ctx.st.pend,
                                       end_of_run: 1'b1};
                push_c.cnt = ctx.n + 2'd1;
            end
            st_next = upds_pkg::ST_RESET;
        end

        push = push_c;
        if (!fire) push.cnt = 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            st_reg <= upds_pkg::ST_RESET;
        end else if (fire) begin
            st_reg <= st_next;
        end
    end

    `UPDS_ASSERT_NEXT(a_last_resets, clk, rst_n, fire && last_byte, st_reg == upds_pkg::ST_RESET, "scan state not cleared after final byte")

endmodule

// File: hdl/upds_fifo.sv
// Output word queue: takes up to three words a cycle, hands out one.
// Depends on upds_pkg and the assertion macro header.
`include "url_path_decode_sanitize_top_assert.svh"

module upds_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  upds_pkg::push_t     push,
    input  logic                pop,
    output logic                room,
    output logic                head_valid,
    output upds_pkg::out_item_t head
);

    upds_pkg::out_item_t mem_reg [upds_pkg::FIFO_DEPTH];
    logic [upds_pkg::FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [upds_pkg::FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [upds_pkg::FIFO_CNT_W-1:0] count_reg;
    logic [upds_pkg::FIFO_CNT_W-1:0] count_next;
    logic                            do_pop;

    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign room       = (count_reg <= upds_pkg::FIFO_ROOM_LIMIT);
    assign do_pop     = pop && head_valid;
    assign count_next = count_reg + upds_pkg::FIFO_CNT_W'(push.cnt)
                        - upds_pkg::FIFO_CNT_W'(do_pop);

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < upds_pkg::PUSH_MAX; k++) begin
            if (2'(k) < push.cnt) begin
                mem_reg[upds_pkg::FIFO_PTR_W'(wr_ptr_reg + upds_pkg::FIFO_PTR_W'(k))] <=
                    push.item[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + upds_pkg::FIFO_PTR_W'(push.cnt);
            rd_ptr_reg <= rd_ptr_reg + upds_pkg::FIFO_PTR_W'(do_pop);
            count_reg  <= count_next;
        end
    end

    `UPDS_ASSERT(a_count_bound, clk, rst_n, count_reg <= upds_pkg::FIFO_CNT_W'(upds_pkg::FIFO_DEPTH), "queue count beyond depth")
    `UPDS_ASSERT(a_push_room, clk, rst_n, (push.cnt == 2'd0) || room, "words pushed without room for three")
    `UPDS_ASSERT_NEXT(a_pop_drains, clk, rst_n, do_pop && (push.cnt == 2'd0), count_reg == ($past(count_reg) - 1'b1), "pop without push did not drop the count")

endmodule

// File: hdl/url_path_decode_sanitize_top.sv
// URL path decoder top level: input word register, per-byte scanner, output queue.
// An accepted byte is registered, then scanned into the output queue; words leave from its head.
// Throughput (no stalls): one byte per cycle; a byte makes 0 to 3 words, leaving one per cycle.
// The input stalls while the 8-word output queue has fewer than three free places.
// Reset (rst_n low, asynchronous) empties the queue and returns the scanner to copy mode.
// Depends on upds_pkg, upds_step and upds_fifo.
module url_path_decode_sanitize_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] url_byte,
    input  logic       last_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       kind,
    output logic [7:0] path_byte,
    output logic [1:0] verdict,
    output logic       end_of_run
);

    logic                vld_reg;
    logic [7:0]          byte_reg;
    logic                last_reg;
    logic                room;
    logic                fire;
    logic                take;
    upds_pkg::push_t     push;
    upds_pkg::out_item_t head;

    assign fire     = vld_reg && room;
    assign in_stall = vld_reg && !room;
    assign take     = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= 1'b0;
        end else if (take) begin
            vld_reg <= 1'b1;
        end else if (fire) begin
            vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take) begin
            byte_reg <= url_byte;
            last_reg <= last_byte;
        end
    end

    upds_step u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .url_byte  (byte_reg),
        .last_byte (last_reg),
        .push      (push)
    );

    upds_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop        (!out_stall),
        .room       (room),
        .head_valid (out_valid),
        .head       (head)
    );

    assign kind       = head.kind;
    assign path_byte  = head.path_byte;
    assign verdict    = head.verdict;
    assign end_of_run = head.end_of_run;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for url_path_decode_sanitize_top: a scoreboard class
// predicts every output word from the accepted URL bytes and checks the stream.
// Depends on upds_pkg and the RTL under hdl/.
module testbench;

    localparam int LONG_HOLD   = 60;
    localparam int ITEM_TARGET = 210;

    class path_scoreboard;
        upds_pkg::mode_t     mode;
        logic [7:0]          held_byte;
        logic [1:0]          dot_phase;
        int unsigned         slash_runs;
        int unsigned         dotdot_runs;
        int unsigned         emitted;
        logic [1:0]          pend;
        logic [7:0]          step_bytes [3];
        int                  step_n;
        upds_pkg::out_item_t expected_words [$];
        int                  errors;
        int                  noted_bytes;
        int                  words_checked;
        int                  urls_done;
        int                  verdict_seen [4];

        function new();
            errors        = 0;
            noted_bytes   = 0;
            words_checked = 0;
            urls_done     = 0;
            foreach (verdict_seen[i])
                verdict_seen[i] = 0;
            clear_state();
        endfunction

        function void clear_state();
            mode        = upds_pkg::MODE_NORMAL;
            held_byte   = 8'h00;
            dot_phase   = 2'd0;
            slash_runs  = 0;
            dotdot_runs = 0;
            emitted     = 0;
            pend        = upds_pkg::VERDICT_OK;
        endfunction

        function bit banned(logic [7:0] v);
            case (v)
                8'h21, 8'h22, 8'h23, 8'h26, 8'h27, 8'h2a,
                8'h3b, 8'h3c, 8'h3e, 8'h3f, 8'h60, 8'h7c: return 1'b1;
                default: return 1'b0;
            endcase
        endfunction

        function int hex_digit(logic [7:0] c);
            if (c >= "0" && c <= "9")
                return int'(c) - int'("0");
            if (c >= "a" && c <= "f")
                return int'(c) - int'("a") + 10;
            if (c >= "A" && c <= "F")
                return int'(c) - int'("A") + 10;
            return -1;
        endfunction

        // first verdict wins; scanning stops either way
        function void close_scan(logic [1:0] v);
            if (pend == upds_pkg::VERDICT_OK)
                pend = v;
            mode = upds_pkg::MODE_DONE;
        endfunction

        function void put(logic [7:0] b);
            if (mode == upds_pkg::MODE_DONE)
                return;
            if (emitted >= upds_pkg::MAX_URL_BYTES || step_n >= 3)
            begin
                close_scan(upds_pkg::VERDICT_OVFL);
                return;
            end
            emitted++;
            step_bytes[step_n] = b;
            step_n++;
        endfunction

        function void plain(logic [7:0] c, logic last);
            if (mode == upds_pkg::MODE_DONE)
                return;
            if (c == upds_pkg::CH_PCT)
            begin
                if (last)
                    put(c);
                else
                    mode = upds_pkg::MODE_PCT0;
            end
            else if (c == upds_pkg::CH_QMARK)
                close_scan(upds_pkg::VERDICT_OK);
            else if (c == upds_pkg::CH_SLASH)
            begin
                if (slash_runs < 2047)
                    slash_runs++;
                if (last)
                    put(upds_pkg::CH_SLASH);
                else
                    mode = upds_pkg::MODE_SLASH;
            end
            else if (banned(c))
                close_scan(upds_pkg::VERDICT_FORBID);
            else
                put(c);
        endfunction

        function void note_byte(logic [7:0] c, logic last);
            int                  h1;
            int                  h2;
            logic [7:0]          v;
            logic [7:0]          want;
            upds_pkg::out_item_t w;

            noted_bytes++;
            step_n = 0;
            case (mode)
                upds_pkg::MODE_NORMAL: plain(c, last);
                upds_pkg::MODE_PCT0:
                begin
                    if (last)
                    begin
                        mode = upds_pkg::MODE_NORMAL;
                        put(upds_pkg::CH_PCT);
                        plain(c, 1'b1);
                    end
                    else
                    begin
                        held_byte = c;
                        mode      = upds_pkg::MODE_PCT1;
                    end
                end
                upds_pkg::MODE_PCT1:
                begin
                    h1 = hex_digit(held_byte);
                    h2 = hex_digit(c);
                    v  = 8'h00;
                    if (h1 >= 0)
                        v = (h2 >= 0) ? 8'(h1 * 16 + h2) : 8'(h1);
                    mode = upds_pkg::MODE_NORMAL;
                    if (banned(v))
                        close_scan(upds_pkg::VERDICT_FORBID);
                    else
                        put(v);
                end
                upds_pkg::MODE_SLASH:
                begin
                    if (c == upds_pkg::CH_SLASH)
                    begin
                        if (last)
                            put(upds_pkg::CH_SLASH);
                    end
                    else if (c == upds_pkg::CH_DOT)
                    begin
                        if (last)
                        begin
                            mode = upds_pkg::MODE_NORMAL;
                            put(upds_pkg::CH_SLASH);
                            put(upds_pkg::CH_DOT);
                        end
                        else
                            mode = upds_pkg::MODE_DOT;
                    end
                    else
                    begin
                        mode = upds_pkg::MODE_NORMAL;
                        put(upds_pkg::CH_SLASH);
                        plain(c, last);
                    end
                end
                upds_pkg::MODE_DOT:
                begin
                    if (last)
                    begin
                        mode = upds_pkg::MODE_NORMAL;
                        put(upds_pkg::CH_SLASH);
                        put(upds_pkg::CH_DOT);
                        plain(c, 1'b1);
                    end
                    else if (c == upds_pkg::CH_DOT)
                    begin
                        dot_phase   = 2'd2;
                        dotdot_runs = 0;
                        mode        = upds_pkg::MODE_MATCH;
                    end
                    else
                        close_scan(upds_pkg::VERDICT_OK);
                end
                upds_pkg::MODE_MATCH:
                begin
                    want = (dot_phase >= 2'd2) ? upds_pkg::CH_SLASH : upds_pkg::CH_DOT;
                    if (c != want)
                        close_scan(upds_pkg::VERDICT_OK);
                    else if (dot_phase >= 2'd2)
                    begin
                        dot_phase = 2'd0;
                        if (dotdot_runs < 2047)
                            dotdot_runs++;
                        if (dotdot_runs >= slash_runs)
                            close_scan(upds_pkg::VERDICT_TRAV);
                    end
                    else
                        dot_phase++;
                end
                default: ;
            endcase

            for (int i = 0; i < step_n; i++)
            begin
                w = '{kind: upds_pkg::KIND_PATH, path_byte: step_bytes[i],
                      verdict: upds_pkg::VERDICT_OK, end_of_run: 1'b0};
                // three path words on the final byte: the third one carries the verdict
                if (last && i == 2)
                begin
                    w.verdict    = pend;
                    w.end_of_run = 1'b1;
                end
                expected_words = {expected_words, w};
            end
            if (last)
            begin
                if (step_n < 3)
                begin
                    w = '{kind: upds_pkg::KIND_VERDICT, path_byte: 8'h00, verdict: pend,
                          end_of_run: 1'b1};
                    expected_words = {expected_words, w};
                end
                verdict_seen[pend]++;
                urls_done++;
                clear_state();
            end
        endfunction

        function void flag(string what, upds_pkg::out_item_t want, upds_pkg::out_item_t got);
            errors++;
            if (errors <= 10)
                $display("%0t: %s: expected kind=%0d byte=%02h verdict=%0d end=%0d, got kind=%0d byte=%02h verdict=%0d end=%0d",
                         $realtime, what, want.kind, want.path_byte, want.verdict,
                         want.end_of_run, got.kind, got.path_byte, got.verdict,
                         got.end_of_run);
        endfunction

        function void check_word(logic k, logic [7:0] pb, logic [1:0] v, logic eor);
            upds_pkg::out_item_t got;
            upds_pkg::out_item_t want;

            got = '{kind: k, path_byte: pb, verdict: v, end_of_run: eor};
            words_checked++;
            if (expected_words.size() == 0)
            begin
                want = '0;
                flag("word with nothing expected", want, got);
                return;
            end
            want = expected_words.pop_front();
            if (got.kind !== want.kind || got.path_byte !== want.path_byte ||
                got.verdict !== want.verdict || got.end_of_run !== want.end_of_run)
                flag("word mismatch", want, got);
        endfunction
    endclass

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       in_valid   = 1'b0;
    logic       in_stall;
    logic [7:0] url_byte   = 8'h00;
    logic       last_byte  = 1'b0;
    logic       out_valid;
    logic       out_stall  = 1'b1;
    logic       kind;
    logic [7:0] path_byte;
    logic [1:0] verdict;
    logic       end_of_run;

    bit steady   = 1'b0;
    bit hold_req = 1'b0;

    path_scoreboard sb = new();

    url_path_decode_sanitize_top u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .url_byte   (url_byte),
        .last_byte  (last_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .path_byte  (path_byte),
        .verdict    (verdict),
        .end_of_run (end_of_run)
    );

    always #1 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 8);
        return $urandom_range(15, 40);
    endfunction

    task automatic send_byte(logic [7:0] b, logic last);
        in_valid  <= 1'b1;
        url_byte  <= b;
        last_byte <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_byte(b, last);
        if (!steady && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat (pick_gap()) @(posedge clk);
        end
    endtask

    task automatic send_url(logic [7:0] q [$]);
        foreach (q[i])
            send_byte(q[i], i == q.size() - 1);
    endtask

    task automatic send_text(string s);
        logic [7:0] q [$];
        foreach (s[i])
            q = {q, s[i]};
        send_url(q);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.expected_words.size() != 0)
            @(posedge clk);
    endtask

    // mostly well-formed path pieces, with some noise and cut-off groups
    function automatic void random_url(ref logic [7:0] q [$]);
        string      safe = "abcdefxyzABCDEF0123456789-_~.";
        string      hexc = "0123456789abcdefABCDEF";
        logic [7:0] bad_chars [11] = '{8'h21, 8'h22, 8'h23, 8'h26, 8'h27, 8'h2a,
                                       8'h3b, 8'h3c, 8'h3e, 8'h60, 8'h7c};
        int         tokens;
        int         r;
        int         n;

        tokens = $urandom_range(1, 8);
        repeat (tokens)
        begin
            r = $urandom_range(0, 99);
            if (r < 30)
                q = {q, safe[$urandom_range(0, safe.len() - 1)]};
            else if (r < 45)
            begin
                n = $urandom_range(1, 3);
                repeat (n) q = {q, upds_pkg::CH_SLASH};
            end
            else if (r < 60)
            begin
                q = {q, upds_pkg::CH_PCT};
                q = {q, hexc[$urandom_range(0, hexc.len() - 1)]};
                q = {q, hexc[$urandom_range(0, hexc.len() - 1)]};
            end
            else if (r < 65)
            begin
                q = {q, upds_pkg::CH_PCT};
                q = {q, 8'($urandom_range(0, 255))};
                q = {q, 8'($urandom_range(0, 255))};
            end
            else if (r < 77)
            begin
                q = {q, upds_pkg::CH_SLASH};
                n = $urandom_range(1, 3);
                repeat (n)
                begin
                    q = {q, upds_pkg::CH_DOT};
                    q = {q, upds_pkg::CH_DOT};
                    q = {q, upds_pkg::CH_SLASH};
                end
            end
            else if (r < 82)
            begin
                q = {q, upds_pkg::CH_SLASH};
                q = {q, upds_pkg::CH_DOT};
                q = {q, upds_pkg::CH_SLASH};
            end
            else if (r < 85)
                q = {q, upds_pkg::CH_QMARK};
            else if (r < 90)
                q = {q, bad_chars[$urandom_range(0, 10)]};
            else
                q = {q, 8'($urandom_range(0, 255))};
        end
    endfunction

    // receiver: random stall gaps, a long counted hold-off on request
    initial
    begin : receiver
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                quiet    = LONG_HOLD;
            end
            if (quiet > 0)
            begin
                out_stall <= 1'b1;
                quiet--;
            end
            else if (steady)
                out_stall <= 1'b0;
            else
            begin
                quiet = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
                out_stall <= (quiet > 0);
                if (quiet > 0)
                    quiet--;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_word(kind, path_byte, verdict, end_of_run);
    end

    initial
    begin : stimulus
        logic [7:0] q [$];
        int         random_urls;

        random_urls = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // collapse, upper-case hex escape, non-hex escape, half-hex escape
        send_text("//a%4A%zz%3q");
        send_text("a%21");
        send_text("/../x");
        // slash and dot held until the final byte: three words, verdict merged
        send_text("/.x");
        q = {8'h00, 8'hff, upds_pkg::CH_PCT, "b"};
        send_url(q);
        send_text("/%");
        send_text("b?!");
        send_text("c<d");
        send_text("/a/../../x");
        wait_drained();

        // receiver holds off while bytes keep coming: queue fills, input stalls
        steady   = 1'b1;
        hold_req = 1'b1;
        q = {};
        repeat (24) q = {q, 8'h6b};
        send_url(q);
        steady = 1'b0;
        wait_drained();

        while (sb.noted_bytes < ITEM_TARGET)
        begin
            q = {};
            random_url(q);
            steady = ($urandom_range(0, 4) == 0);
            send_url(q);
            random_urls++;
            if ($urandom_range(0, 9) == 0)
                wait_drained();
        end
        steady = 1'b0;

        wait_drained();
        repeat (20) @(posedge clk);
        $display("%0d URLs (%0d random) from %0d bytes, %0d words checked, %0d errors",
                 sb.urls_done, random_urls, sb.noted_bytes, sb.words_checked, sb.errors);
        $display("verdicts: accepted %0d, forbidden %0d, traversal %0d, overflow %0d",
                 sb.verdict_seen[upds_pkg::VERDICT_OK], sb.verdict_seen[upds_pkg::VERDICT_FORBID],
                 sb.verdict_seen[upds_pkg::VERDICT_TRAV], sb.verdict_seen[upds_pkg::VERDICT_OVFL]);
        if (sb.errors == 0 && sb.expected_words.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin : watchdog
        #1600000;
        $display("timeout with %0d words outstanding", sb.expected_words.size());
        $display("simulation failed");
        $finish;
    end

endmodule
